@@ src/trcp_pkg.sv @@
// shared widths, codes and constants of the triangle closest-point block
package trcp_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int EDGE_W    = COORD_WIDTH + 1;
   localparam int DOT_W     = 2 * EDGE_W + 1;
   localparam int WIDE_W    = 2 * DOT_W + 2;
   localparam int SUM_W     = WIDE_W + 1;
   localparam int LO_W      = (DOT_W + 1) / 2;
   localparam int HI_W      = DOT_W - LO_W;
   localparam int COORD_U_W = FRAC_BITS + 1;
   localparam int MIX_W     = EDGE_W + FRAC_BITS + 3;

   localparam logic [COORD_U_W-1:0] ONE_Q = COORD_U_W'(1) << FRAC_BITS;

   localparam int DIV_LAT  = FRAC_BITS + 1;
   localparam int PIPE_LEN = DIV_LAT + 10;

   localparam int REQ_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_U_W + 2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_USER_W = 3;

   localparam int CSR_DATA_W   = (COORD_WIDTH > 32) ? 64 : 32;
   localparam int CSR_STRIDE_W = (COORD_WIDTH > 32) ? 3 : 2;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_ADDR_W   = CSR_IDX_W + CSR_STRIDE_W;

   typedef enum logic [1:0] {
      REGION_INTERIOR,
      REGION_EDGE_AC,
      REGION_EDGE_AB,
      REGION_EDGE_BC
   } region_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VERTEX_A_X,
      REG_VERTEX_A_Y,
      REG_VERTEX_B_X,
      REG_VERTEX_B_Y,
      REG_VERTEX_C_X,
      REG_VERTEX_C_Y
   } csr_index_type;

endpackage

@@ src/trcp_divider.sv @@
// pipelined restoring divider giving a clamped fraction n/d in unsigned Q1.F
module trcp_divider (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic signed [trcp_pkg::WIDE_W-1:0]   num,
   input  logic signed [trcp_pkg::WIDE_W-1:0]   den,
   output logic        [trcp_pkg::COORD_U_W-1:0] quot
);
   import trcp_pkg::*;

   logic                 zero_ff [0:FRAC_BITS];
   logic                 one_ff  [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_ff  [0:FRAC_BITS];
   logic [WIDE_W-1:0]    rem_ff  [0:FRAC_BITS-1];
   logic [WIDE_W-1:0]    den_ff  [0:FRAC_BITS-1];

   logic                 zero_in;
   logic                 one_in;
   logic [WIDE_W:0]      dbl  [1:FRAC_BITS];
   logic [WIDE_W:0]      diff [1:FRAC_BITS];
   logic [FRAC_BITS:1]   take;

   always_comb begin
      zero_in = num[WIDE_W-1] || (num == '0);
      one_in  = !zero_in && (num >= den);
      for (int k = 1; k <= FRAC_BITS; k++) begin
         dbl[k]  = {rem_ff[k-1], 1'b0};
         diff[k] = dbl[k] - {1'b0, den_ff[k-1]};
         take[k] = !diff[k][WIDE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= zero_in;
         one_ff[0]  <= one_in;
         quo_ff[0]  <= '0;
         rem_ff[0]  <= (zero_in || one_in) ? '0 : num;
         den_ff[0]  <= den;
         for (int k = 1; k <= FRAC_BITS; k++) begin
            zero_ff[k] <= zero_ff[k-1];
            one_ff[k]  <= one_ff[k-1];
            quo_ff[k]  <= {quo_ff[k-1][FRAC_BITS-2:0], take[k]};
         end
         for (int k = 1; k < FRAC_BITS; k++) begin
            rem_ff[k] <= take[k] ? diff[k][WIDE_W-1:0] : dbl[k][WIDE_W-1:0];
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quot = one_ff[FRAC_BITS]  ? ONE_Q :
                 zero_ff[FRAC_BITS] ? '0    : COORD_U_W'(quo_ff[FRAC_BITS]);

endmodule

@@ src/triangle_closest_point.sv @@
// closest point on a 2d triangle: top level with register file and datapath
//
// Streams query points against a triangle held in six csr registers and returns, for each
// point, the plane coordinates (u, v), the nearest point on the triangle, the region code and
// a degenerate flag. One beat is taken every cycle unless the output is stalled; the pipeline
// depth is set by the 16 restoring steps of the two fraction dividers plus the split wide
// multiplies of the determinant terms. The whole pipeline holds while a result waits on
// rsp_tready, so req_tready falls only then. Vertex registers must be written only while no
// query is in flight; the block itself does not enforce this.
module triangle_closest_point (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [trcp_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [trcp_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [trcp_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // query_x, query_y
   input  logic [trcp_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // coord_u, coord_v, nearest_x, nearest_y, zero fill
   output logic [trcp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // region, degenerate
   output logic [trcp_pkg::RSP_USER_W-1:0]       rsp_tuser
);
   import trcp_pkg::*;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [EDGE_W-1:0]      e1x;
      logic signed [EDGE_W-1:0]      e1y;
      logic signed [EDGE_W-1:0]      e2x;
      logic signed [EDGE_W-1:0]      e2y;
   } geo_type;

   typedef struct packed {
      region_type region;
      logic       degen;
      geo_type    geo;
   } side_type;

   typedef struct packed {
      logic signed [WIDE_W-1:0] neg_d;
      logic signed [WIDE_W-1:0] neg_e;
      logic signed [WIDE_W-1:0] num_bc;
      logic signed [WIDE_W-1:0] den_bc;
      logic signed [WIDE_W-1:0] dot_a;
      logic signed [WIDE_W-1:0] dot_c;
   } edge_type;

   typedef struct packed {
      logic signed [2*HI_W-1:0]   hh;
      logic signed [HI_W+LO_W:0]  hl;
      logic signed [HI_W+LO_W:0]  lh;
      logic        [2*LO_W-1:0]   ll;
   } pp_type;

   function automatic logic signed [DOT_W-1:0] dot2(
      input logic signed [EDGE_W-1:0] x1, input logic signed [EDGE_W-1:0] y1,
      input logic signed [EDGE_W-1:0] x2, input logic signed [EDGE_W-1:0] y2);
      logic signed [2*EDGE_W-1:0] px;
      logic signed [2*EDGE_W-1:0] py;
      px = x1 * x2;
      py = y1 * y2;
      return DOT_W'(px) + DOT_W'(py);
   endfunction

   function automatic pp_type pp_make(input logic signed [DOT_W-1:0] a,
                                      input logic signed [DOT_W-1:0] b);
      logic signed [HI_W-1:0] ah;
      logic signed [HI_W-1:0] bh;
      logic [LO_W-1:0]        al;
      logic [LO_W-1:0]        bl;
      pp_type                 r;
      ah   = a[DOT_W-1:LO_W];
      bh   = b[DOT_W-1:LO_W];
      al   = a[LO_W-1:0];
      bl   = b[LO_W-1:0];
      r.hh = ah * bh;
      r.hl = ah * signed'({1'b0, bl});
      r.lh = signed'({1'b0, al}) * bh;
      r.ll = al * bl;
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] pp_sum(input pp_type p);
      logic signed [WIDE_W-1:0] hh;
      logic signed [WIDE_W-1:0] mid;
      logic        [WIDE_W-1:0] ll;
      hh  = WIDE_W'(signed'(p.hh));
      mid = WIDE_W'(signed'(p.hl)) + WIDE_W'(signed'(p.lh));
      ll  = WIDE_W'(p.ll);
      return (hh <<< (2 * LO_W)) + (mid <<< LO_W) + ll;
   endfunction

   function automatic logic signed [MIX_W-1:0] mul_mix(input logic signed [EDGE_W-1:0] e,
                                                      input logic [COORD_U_W-1:0] w);
      logic signed [MIX_W-1:0] r;
      r = e * signed'({1'b0, w});
      return r;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [MIX_W-1:0] acc);
      logic signed [MIX_W-FRAC_BITS-1:0] sh;
      logic [MIX_W-FRAC_BITS-COORD_WIDTH:0] top;
      sh  = acc[MIX_W-1:FRAC_BITS];
      top = sh[MIX_W-FRAC_BITS-1:COORD_WIDTH-1];
      if ((&top) || !(|top)) begin
         return sh[COORD_WIDTH-1:0];
      end else if (sh[MIX_W-FRAC_BITS-1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   // csr registers
   logic signed [COORD_WIDTH-1:0] vertex_a_x_ff, vertex_a_y_ff;
   logic signed [COORD_WIDTH-1:0] vertex_b_x_ff, vertex_b_y_ff;
   logic signed [COORD_WIDTH-1:0] vertex_c_x_ff, vertex_c_y_ff;
   logic                          csr_write;
   csr_index_type                 csr_index;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_STRIDE_W]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_x_ff <= '0;
         vertex_a_y_ff <= '0;
         vertex_b_x_ff <= '0;
         vertex_b_y_ff <= '0;
         vertex_c_x_ff <= '0;
         vertex_c_y_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_VERTEX_A_X: vertex_a_x_ff <= csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_A_Y: vertex_a_y_ff <= csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_B_X: vertex_b_x_ff <= csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_B_Y: vertex_b_y_ff <= csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_C_X: vertex_c_x_ff <= csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_C_Y: vertex_c_y_ff <= csr_pwdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_VERTEX_A_X: csr_prdata = CSR_DATA_W'($unsigned(vertex_a_x_ff));
         REG_VERTEX_A_Y: csr_prdata = CSR_DATA_W'($unsigned(vertex_a_y_ff));
         REG_VERTEX_B_X: csr_prdata = CSR_DATA_W'($unsigned(vertex_b_x_ff));
         REG_VERTEX_B_Y: csr_prdata = CSR_DATA_W'($unsigned(vertex_b_y_ff));
         REG_VERTEX_C_X: csr_prdata = CSR_DATA_W'($unsigned(vertex_c_x_ff));
         REG_VERTEX_C_Y: csr_prdata = CSR_DATA_W'($unsigned(vertex_c_y_ff));
         default:        csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic [PIPE_LEN-1:0] valid_ff;
   logic                pipe_en;

   assign pipe_en    = !valid_ff[PIPE_LEN-1] || rsp_tready;
   assign req_tready = pipe_en;
   assign rsp_tvalid = valid_ff[PIPE_LEN-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[PIPE_LEN-2:0], req_tvalid};
      end
   end

   // stage registers
   geo_type                  geo1_ff, geo2_ff, geo3_ff, geo4_ff, geo5_ff;
   logic signed [EDGE_W-1:0] x0x1_ff, x0y1_ff;
   logic signed [DOT_W-1:0]  dot_a2_ff, dot_b2_ff, dot_c2_ff, dot_d2_ff, dot_e2_ff;
   pp_type                   pp_ac3_ff, pp_bb3_ff, pp_be3_ff, pp_cd3_ff, pp_bd3_ff, pp_ae3_ff;
   edge_type                 edge3_ff, edge4_ff, edge5_ff;
   logic signed [WIDE_W-1:0] ac4_ff, bb4_ff, be4_ff, cd4_ff, bd4_ff, ae4_ff;
   logic signed [WIDE_W-1:0] det5_ff, sx5_ff, sy5_ff;
   side_type                 side6_ff;
   logic signed [WIDE_W-1:0] num_u6_ff, den_u6_ff, num_v6_ff, den_v6_ff;
   side_type                 side_ff [0:DIV_LAT-1];
   side_type                 side7_ff, side8_ff;
   logic [COORD_U_W-1:0]     u7_ff, v7_ff, u8_ff, v8_ff, u9_ff, v9_ff;
   logic signed [MIX_W-1:0]  pux8_ff, puy8_ff, pvx8_ff, pvy8_ff;
   logic signed [MIX_W-1:0]  acc_x9_ff, acc_y9_ff;
   region_type               region9_ff;
   logic                     degen9_ff;
   logic [COORD_U_W-1:0]     out_u_ff, out_v_ff;
   logic [COORD_WIDTH-1:0]   out_x_ff, out_y_ff;
   region_type               out_region_ff;
   logic                     out_degen_ff;

   // next values
   geo_type                  geo1_in;
   logic signed [EDGE_W-1:0] x0x1_in, x0y1_in;
   edge_type                 edge3_in;
   side_type                 side6_in;
   logic signed [WIDE_W-1:0] num_u6_in, den_u6_in, num_v6_in, den_v6_in;
   logic signed [SUM_W-1:0]  bc_diff;
   logic [COORD_U_W-1:0]     quot_u, quot_v;
   logic [COORD_U_W-1:0]     u7_in;
   logic signed [MIX_W-1:0]  acc_x9_in, acc_y9_in;

   always_comb begin
      geo1_in.ax  = vertex_a_x_ff;
      geo1_in.ay  = vertex_a_y_ff;
      geo1_in.e1x = EDGE_W'(vertex_b_x_ff) - EDGE_W'(vertex_a_x_ff);
      geo1_in.e1y = EDGE_W'(vertex_b_y_ff) - EDGE_W'(vertex_a_y_ff);
      geo1_in.e2x = EDGE_W'(vertex_c_x_ff) - EDGE_W'(vertex_a_x_ff);
      geo1_in.e2y = EDGE_W'(vertex_c_y_ff) - EDGE_W'(vertex_a_y_ff);
      x0x1_in = EDGE_W'(vertex_a_x_ff) - EDGE_W'(signed'(req_tdata[COORD_WIDTH-1:0]));
      x0y1_in = EDGE_W'(vertex_a_y_ff)
                - EDGE_W'(signed'(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));

      edge3_in.neg_d  = -WIDE_W'(dot_d2_ff);
      edge3_in.neg_e  = -WIDE_W'(dot_e2_ff);
      edge3_in.num_bc = WIDE_W'(dot_a2_ff) - WIDE_W'(dot_b2_ff)
                        + WIDE_W'(dot_d2_ff) - WIDE_W'(dot_e2_ff);
      edge3_in.den_bc = WIDE_W'(dot_a2_ff) - (WIDE_W'(dot_b2_ff) <<< 1) + WIDE_W'(dot_c2_ff);
      edge3_in.dot_a  = WIDE_W'(dot_a2_ff);
      edge3_in.dot_c  = WIDE_W'(dot_c2_ff);

      // region pick and divider operands
      side6_in.geo    = geo5_ff;
      side6_in.degen  = (det5_ff == '0);
      side6_in.region = REGION_INTERIOR;
      num_u6_in = '0;
      den_u6_in = det5_ff;
      num_v6_in = '0;
      den_v6_in = det5_ff;
      bc_diff   = SUM_W'(sx5_ff) + SUM_W'(sy5_ff) - SUM_W'(det5_ff);
      if (!side6_in.degen) begin
         if (sx5_ff[WIDE_W-1]) begin
            side6_in.region = REGION_EDGE_AC;
            num_v6_in = edge5_ff.neg_e;
            den_v6_in = edge5_ff.dot_c;
         end else if (sy5_ff[WIDE_W-1]) begin
            side6_in.region = REGION_EDGE_AB;
            num_u6_in = edge5_ff.neg_d;
            den_u6_in = edge5_ff.dot_a;
         end else if (!bc_diff[SUM_W-1] && (bc_diff != '0)) begin
            side6_in.region = REGION_EDGE_BC;
            num_v6_in = edge5_ff.num_bc;
            den_v6_in = edge5_ff.den_bc;
         end else begin
            num_u6_in = sx5_ff;
            num_v6_in = sy5_ff;
         end
      end

      u7_in = (side_ff[DIV_LAT-1].region == REGION_EDGE_BC) ? ONE_Q - quot_v : quot_u;

      acc_x9_in = (MIX_W'(signed'(side8_ff.geo.ax)) <<< FRAC_BITS) + pux8_ff + pvx8_ff;
      acc_y9_in = (MIX_W'(signed'(side8_ff.geo.ay)) <<< FRAC_BITS) + puy8_ff + pvy8_ff;
   end

   trcp_divider u_div_u (
      .clock  (clock),
      .enable (pipe_en),
      .num    (num_u6_ff),
      .den    (den_u6_ff),
      .quot   (quot_u)
   );

   trcp_divider u_div_v (
      .clock  (clock),
      .enable (pipe_en),
      .num    (num_v6_ff),
      .den    (den_v6_ff),
      .quot   (quot_v)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         geo1_ff <= geo1_in;
         x0x1_ff <= x0x1_in;
         x0y1_ff <= x0y1_in;

         geo2_ff   <= geo1_ff;
         dot_a2_ff <= dot2(geo1_ff.e1x, geo1_ff.e1y, geo1_ff.e1x, geo1_ff.e1y);
         dot_b2_ff <= dot2(geo1_ff.e1x, geo1_ff.e1y, geo1_ff.e2x, geo1_ff.e2y);
         dot_c2_ff <= dot2(geo1_ff.e2x, geo1_ff.e2y, geo1_ff.e2x, geo1_ff.e2y);
         dot_d2_ff <= dot2(geo1_ff.e1x, geo1_ff.e1y, x0x1_ff, x0y1_ff);
         dot_e2_ff <= dot2(geo1_ff.e2x, geo1_ff.e2y, x0x1_ff, x0y1_ff);

         geo3_ff   <= geo2_ff;
         edge3_ff  <= edge3_in;
         pp_ac3_ff <= pp_make(dot_a2_ff, dot_c2_ff);
         pp_bb3_ff <= pp_make(dot_b2_ff, dot_b2_ff);
         pp_be3_ff <= pp_make(dot_b2_ff, dot_e2_ff);
         pp_cd3_ff <= pp_make(dot_c2_ff, dot_d2_ff);
         pp_bd3_ff <= pp_make(dot_b2_ff, dot_d2_ff);
         pp_ae3_ff <= pp_make(dot_a2_ff, dot_e2_ff);

         geo4_ff  <= geo3_ff;
         edge4_ff <= edge3_ff;
         ac4_ff   <= pp_sum(pp_ac3_ff);
         bb4_ff   <= pp_sum(pp_bb3_ff);
         be4_ff   <= pp_sum(pp_be3_ff);
         cd4_ff   <= pp_sum(pp_cd3_ff);
         bd4_ff   <= pp_sum(pp_bd3_ff);
         ae4_ff   <= pp_sum(pp_ae3_ff);

         geo5_ff  <= geo4_ff;
         edge5_ff <= edge4_ff;
         det5_ff  <= ac4_ff - bb4_ff;
         sx5_ff   <= be4_ff - cd4_ff;
         sy5_ff   <= bd4_ff - ae4_ff;

         side6_ff  <= side6_in;
         num_u6_ff <= num_u6_in;
         den_u6_ff <= den_u6_in;
         num_v6_ff <= num_v6_in;
         den_v6_ff <= den_v6_in;

         side_ff[0] <= side6_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end

         side7_ff <= side_ff[DIV_LAT-1];
         u7_ff    <= u7_in;
         v7_ff    <= quot_v;

         side8_ff <= side7_ff;
         u8_ff    <= u7_ff;
         v8_ff    <= v7_ff;
         pux8_ff  <= mul_mix(side7_ff.geo.e1x, u7_ff);
         puy8_ff  <= mul_mix(side7_ff.geo.e1y, u7_ff);
         pvx8_ff  <= mul_mix(side7_ff.geo.e2x, v7_ff);
         pvy8_ff  <= mul_mix(side7_ff.geo.e2y, v7_ff);

         acc_x9_ff  <= acc_x9_in;
         acc_y9_ff  <= acc_y9_in;
         u9_ff      <= u8_ff;
         v9_ff      <= v8_ff;
         region9_ff <= side8_ff.region;
         degen9_ff  <= side8_ff.degen;

         out_u_ff      <= u9_ff;
         out_v_ff      <= v9_ff;
         out_x_ff      <= sat(acc_x9_ff);
         out_y_ff      <= sat(acc_y9_ff);
         out_region_ff <= region9_ff;
         out_degen_ff  <= degen9_ff;
      end
   end

   assign rsp_tdata = RSP_DATA_W'({out_y_ff, out_x_ff, out_v_ff, out_u_ff});
   assign rsp_tuser = {out_degen_ff, out_region_ff};

endmodule

@@ src/trcp_checker.sv @@
// port-level checks of the triangle closest-point block, bound to the top level
module trcp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [trcp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [trcp_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import trcp_pkg::*;

   logic [COORD_U_W-1:0] cu;
   logic [COORD_U_W-1:0] cv;
   logic [1:0]           rg;
   logic                 dg;
   logic [COORD_U_W:0]   uv_sum;

   assign cu     = rsp_tdata[COORD_U_W-1:0];
   assign cv     = rsp_tdata[2*COORD_U_W-1:COORD_U_W];
   assign rg     = rsp_tuser[1:0];
   assign dg     = rsp_tuser[2];
   assign uv_sum = {1'b0, cu} + {1'b0, cv};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dg |-> cu == '0 && cv == '0 && rg == REGION_INTERIOR)
      else $error("degenerate result with nonzero coordinates");

   a_edge_weights: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cu <= ONE_Q && cv <= ONE_Q
                     && !(rg == REGION_EDGE_AC && cu != '0)
                     && !(rg == REGION_EDGE_AB && cv != '0))
      else $error("edge weights out of range");

   a_bc_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rg == REGION_EDGE_BC |-> uv_sum == {1'b0, ONE_Q})
      else $error("edge b-c weights do not sum to one");

endmodule

bind triangle_closest_point trcp_checker u_trcp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
